[rtl/unique_range_match_table_top_macros.svh]
// Assertion macros used by the checker file of the range match table.
`ifndef UNIQUE_RANGE_MATCH_TABLE_TOP_MACROS_SVH
`define UNIQUE_RANGE_MATCH_TABLE_TOP_MACROS_SVH

// General form: label, clock, reset and the property to hold.
`define URMT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("range match table check failed");

// Short form for checkers whose clock and reset are named clock and reset.
`define URMT_CHECK(lbl, prop) `URMT_ASSERT(lbl, clock, reset, prop)

`endif

[rtl/urmt_pkg.sv]
`timescale 1ns / 1ps

package urmt_pkg;

   localparam int unsigned TABLE_ENTRIES_DEF = 1024;
   localparam int unsigned VALUE_BITS = 20;
   localparam int unsigned INDEX_BITS = 10;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_LOAD  = 2'd0;
   localparam kind_type KIND_QUERY = 2'd1;
   localparam kind_type KIND_CLEAR = 2'd2;

   typedef logic [2:0] status_type;
   localparam status_type ST_UNIQUE  = 3'd0;
   localparam status_type ST_NONE    = 3'd1;
   localparam status_type ST_AMBIG   = 3'd2;
   localparam status_type ST_LOADED  = 3'd3;
   localparam status_type ST_FULL    = 3'd4;
   localparam status_type ST_CLEARED = 3'd5;

   typedef struct packed {
      kind_type        kind;
      logic [19:0]     low_bound;
      logic [19:0]     high_bound;
      logic [19:0]     price;
   } req_type;

   typedef struct packed {
      status_type            status;
      logic [INDEX_BITS-1:0] match_index;
   } rsp_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] low;
      logic [VALUE_BITS-1:0] high;
   } bounds_type;

endpackage

[rtl/urmt_store.sv]
`timescale 1ns / 1ps

module urmt_store #(
   parameter int unsigned DEPTH = urmt_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  urmt_pkg::bounds_type                       wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output urmt_pkg::bounds_type                       rd_data
);
   import urmt_pkg::*;

   bounds_type mem_ff [DEPTH];
   bounds_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/unique_range_match_table_top.sv]
`timescale 1ns / 1ps
// Load and clear requests write their result to a result register, and from there
// to the output register once the output is free. A query reads one stored range
// per cycle through the single read port of the bounds memory; a second match ends
// the scan early. One request is worked on at a time: a new request is taken only
// after the last result has moved to the output register.
// Reset empties the table and the output; the bounds memory is not cleared.
module unique_range_match_table_top #(
   parameter int unsigned TABLE_ENTRIES = urmt_pkg::TABLE_ENTRIES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  urmt_pkg::req_type req,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output urmt_pkg::rsp_type rsp
);
   import urmt_pkg::*;

   localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int unsigned AW1   = IDX_W + 1;

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EMIT} state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [VALUE_BITS-1:0] price_ff, price_in;
   logic [IDX_W-1:0]      addr_ff, addr_in;
   logic                  issuing_ff, issuing_in;
   logic                  cmp_valid_ff, cmp_valid_in;
   logic                  cmp_last_ff, cmp_last_in;
   logic [IDX_W-1:0]      cmp_idx_ff, cmp_idx_in;
   logic                  hit_ff, hit_in;
   logic [IDX_W-1:0]      found_ff, found_in;
   rsp_type               res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  accept;
   logic                  full;
   logic                  issue;
   logic                  last_issue;
   logic                  hit;
   logic                  wr_en;
   bounds_type            wr_data;
   bounds_type            rd_data;
   logic [IDX_W+INDEX_BITS-1:0] cmp_idx_wide;
   logic [IDX_W+INDEX_BITS-1:0] found_wide;

   urmt_store #(
      .DEPTH(TABLE_ENTRIES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (issue),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign req_stall  = (state_ff != S_IDLE);
   assign accept     = req_valid && !req_stall;
   assign full       = (count_ff == CNT_W'(TABLE_ENTRIES));
   assign wr_en      = accept && (req.kind == KIND_LOAD) && !full;
   assign wr_data    = '{low: req.low_bound[VALUE_BITS-1:0],
                         high: req.high_bound[VALUE_BITS-1:0]};
   assign issue      = (state_ff == S_SCAN) && issuing_ff;
   assign last_issue = ((AW1'(addr_ff) + AW1'(1)) == AW1'(count_ff));
   assign hit        = cmp_valid_ff && (rd_data.low <= price_ff) &&
                       (rd_data.high >= price_ff);

   // The index field is ten bits wide whatever the table depth.
   assign cmp_idx_wide = {{INDEX_BITS{1'b0}}, cmp_idx_ff};
   assign found_wide   = {{INDEX_BITS{1'b0}}, found_ff};

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      price_in     = price_ff;
      addr_in      = addr_ff;
      issuing_in   = issuing_ff;
      hit_in       = hit_ff;
      found_in     = found_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmp_valid_in = issue;
      cmp_last_in  = last_issue;
      cmp_idx_in   = addr_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req.kind)
                  KIND_LOAD: begin
                     res_in = '{status: (full ? ST_FULL : ST_LOADED), match_index: '0};
                     if (!full) begin
                        count_in = count_ff + CNT_W'(1);
                     end
                     state_in = S_EMIT;
                  end
                  KIND_QUERY: begin
                     price_in = req.price[VALUE_BITS-1:0];
                     hit_in   = 1'b0;
                     addr_in  = '0;
                     if (count_ff == '0) begin
                        res_in   = '{status: ST_NONE, match_index: '0};
                        state_in = S_EMIT;
                     end else begin
                        issuing_in = 1'b1;
                        state_in   = S_SCAN;
                     end
                  end
                  KIND_CLEAR: begin
                     count_in = '0;
                     res_in   = '{status: ST_CLEARED, match_index: '0};
                     state_in = S_EMIT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (issue) begin
               addr_in = addr_ff + IDX_W'(1);
               if (last_issue) begin
                  issuing_in = 1'b0;
               end
            end
            if (hit && hit_ff) begin
               // A second match settles the answer; reads still in flight are dropped.
               issuing_in = 1'b0;
               res_in     = '{status: ST_AMBIG, match_index: '0};
               state_in   = S_EMIT;
            end else begin
               if (hit) begin
                  hit_in   = 1'b1;
                  found_in = cmp_idx_ff;
               end
               if (cmp_valid_ff && cmp_last_ff) begin
                  if (hit) begin
                     res_in = '{status: ST_UNIQUE,
                                match_index: cmp_idx_wide[INDEX_BITS-1:0]};
                  end else if (hit_ff) begin
                     res_in = '{status: ST_UNIQUE,
                                match_index: found_wide[INDEX_BITS-1:0]};
                  end else begin
                     res_in = '{status: ST_NONE, match_index: '0};
                  end
                  state_in = S_EMIT;
               end
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         issuing_ff   <= 1'b0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issuing_ff   <= issuing_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      price_ff    <= price_in;
      addr_ff     <= addr_in;
      cmp_last_ff <= cmp_last_in;
      cmp_idx_ff  <= cmp_idx_in;
      hit_ff      <= hit_in;
      found_ff    <= found_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

[rtl/urmt_check.sv]
`timescale 1ns / 1ps
`include "unique_range_match_table_top_macros.svh"

module urmt_check (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input urmt_pkg::req_type req,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input urmt_pkg::rsp_type rsp
);
   import urmt_pkg::*;

   // A result held back by the receiver stays on the port unchanged.
   `URMT_CHECK(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))

   // Only a unique match carries an index.
   `URMT_CHECK(a_index_zero, rsp_valid && (rsp.status != ST_UNIQUE) |-> rsp.match_index == '0)

   `URMT_CHECK(a_status_known, rsp_valid |-> rsp.status <= ST_CLEARED)

   // Every query occupies the block for at least the following cycle.
   `URMT_CHECK(a_query_busy, req_valid && !req_stall && (req.kind == KIND_QUERY) |=> req_stall)

   // An accepted load sets the request stall.
   `URMT_CHECK(a_load_busy, req_valid && !req_stall && (req.kind == KIND_LOAD) |=> req_stall)

endmodule

bind unique_range_match_table_top urmt_check u_urmt_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req       (req),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp       (rsp)
);

[sim/unique_range_match_table_top_tb.sv]
`timescale 1ns / 1ps

module unique_range_match_table_top_tb;
   import urmt_pkg::*;

   // Requests of this kind are ignored by the block and give no result.
   localparam kind_type KIND_UNUSED = 2'd3;
   localparam int TIMEOUT_CYCLES = 1_500_000;
   localparam int SCAN_SETTLE_CYCLES = 1100;

   typedef struct {
      req_type item;
      bit      hold;
   } pending_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp;

   pending_type pending[$];
   rsp_type     due_answers[$];
   rsp_type     oldest;

   logic [VALUE_BITS-1:0] low_copy [TABLE_ENTRIES_DEF];
   logic [VALUE_BITS-1:0] high_copy[TABLE_ENTRIES_DEF];
   int stored = 0;

   int issued = 0;
   int total_planned = 0;
   int accepted = 0;
   int errors = 0;
   int cycles = 0;
   int status_seen[8];

   unique_range_match_table_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void queue_request(kind_type k, logic [19:0] lo, logic [19:0] hi,
                                         logic [19:0] pr, bit hold);
      pending_type p;
      p.item.kind = k;
      p.item.low_bound = lo;
      p.item.high_bound = hi;
      p.item.price = pr;
      p.hold = hold;
      pending = {pending, p};
   endfunction

   // Applies one accepted request to the table copy and records the answer it must give.
   function automatic void predict_answer(req_type r);
      rsp_type a;
      int hits;
      int slot;
      a = '0;
      accepted++;
      case (r.kind)
         KIND_LOAD: begin
            if (stored == TABLE_ENTRIES_DEF) begin
               a.status = ST_FULL;
            end else begin
               low_copy[stored] = r.low_bound;
               high_copy[stored] = r.high_bound;
               stored++;
               a.status = ST_LOADED;
            end
         end
         KIND_QUERY: begin
            hits = 0;
            // The scan stops at the second hit, so the index of a unique hit is the only one kept.
            for (slot = 0; slot < stored && hits < 2; slot++) begin
               if (low_copy[slot] <= r.price && high_copy[slot] >= r.price) begin
                  hits++;
                  a.match_index = INDEX_BITS'(slot);
               end
            end
            if (hits == 0) begin
               a.status = ST_NONE;
            end else if (hits == 1) begin
               a.status = ST_UNIQUE;
            end else begin
               a.status = ST_AMBIG;
            end
            if (hits != 1) begin
               a.match_index = '0;
            end
         end
         KIND_CLEAR: begin
            stored = 0;
            a.status = ST_CLEARED;
         end
         default: return;
      endcase
      due_answers = {due_answers, a};
   endfunction

   function automatic int idle_phase();
      if (issued < total_planned / 3) begin
         return 0;
      end else if (issued < 2 * total_planned / 3) begin
         return 1;
      end
      return 2;
   endfunction

   function automatic bit sender_idles();
      case (idle_phase())
         0: return $urandom_range(0, 99) < 10;
         1: return $urandom_range(0, 99) < 57;
         default: return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_stalls();
      case (idle_phase())
         0: return $urandom_range(0, 99) < 57;
         1: return $urandom_range(0, 99) < 10;
         default: return 1'b0;
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_answer(req);
         end
         if (!req_valid || !req_stall) begin
            if (pending.size() == 0 || sender_idles() ||
                (pending[0].hold && due_answers.size() != 0)) begin
               req_valid <= 1'b0;
            end else begin
               req <= pending[0].item;
               void'(pending.pop_front());
               req_valid <= 1'b1;
               issued++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            status_seen[rsp.status]++;
            if (due_answers.size() == 0) begin
               errors++;
               $display("%0t: result %p arrived with nothing expected", $time, rsp);
            end else begin
               oldest = due_answers.pop_front();
               if (rsp.status !== oldest.status) begin
                  errors++;
                  $display("%0t: status expected %0d, got %0d", $time, oldest.status,
                           rsp.status);
               end
               if (rsp.match_index !== oldest.match_index) begin
                  errors++;
                  $display("%0t: match_index expected %0d, got %0d", $time,
                           oldest.match_index, rsp.match_index);
               end
            end
         end
         rsp_stall <= receiver_stalls();
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == TIMEOUT_CYCLES) begin
         $display("%0t: timed out with %0d requests pending and %0d results outstanding",
                  $time, pending.size(), due_answers.size());
         $display("unique_range_match_table_top_tb: done, errors");
         $finish;
      end
   end

   initial begin
      int made;
      int table_size;
      int base;
      int nload;
      int nquery;
      int i;
      int j;
      logic [19:0] lo;
      logic [19:0] hi;
      logic [19:0] swap;
      logic [19:0] pr;

      // Small hand-built table: extremes, an inverted range and an overlap.
      queue_request(KIND_QUERY, 20'h0, 20'h0, 20'h0, 1'b0);
      queue_request(KIND_LOAD, 20'h0, 20'h0, 20'h0, 1'b0);
      queue_request(KIND_LOAD, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 1'b0);
      queue_request(KIND_LOAD, 20'd5, 20'd3, 20'h0, 1'b0);
      queue_request(KIND_LOAD, 20'd100, 20'd200, 20'h0, 1'b0);
      queue_request(KIND_LOAD, 20'd150, 20'd300, 20'h0, 1'b0);
      queue_request(KIND_QUERY, 20'h0, 20'h0, 20'h0, 1'b0);
      queue_request(KIND_QUERY, 20'h0, 20'h0, 20'hFFFFF, 1'b0);
      queue_request(KIND_QUERY, 20'h0, 20'h0, 20'd4, 1'b0);
      queue_request(KIND_QUERY, 20'h0, 20'h0, 20'd120, 1'b0);
      queue_request(KIND_QUERY, 20'h0, 20'h0, 20'd160, 1'b0);
      queue_request(KIND_QUERY, 20'h0, 20'h0, 20'd250, 1'b0);
      queue_request(KIND_QUERY, 20'h0, 20'h0, 20'd301, 1'b0);
      queue_request(KIND_UNUSED, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 1'b0);
      queue_request(KIND_LOAD, 20'hFFFFF, 20'h0, 20'h0, 1'b0);
      queue_request(KIND_QUERY, 20'h0, 20'h0, 20'h80000, 1'b0);
      queue_request(KIND_CLEAR, 20'h0, 20'h0, 20'h0, 1'b0);
      queue_request(KIND_QUERY, 20'h0, 20'h0, 20'h0, 1'b0);

      // Fill every slot with disjoint ranges, then load into the full table.
      queue_request(KIND_CLEAR, 20'h0, 20'h0, 20'h0, 1'b1);
      for (i = 0; i < TABLE_ENTRIES_DEF; i++) begin
         queue_request(KIND_LOAD, 20'(i * 16), 20'(i * 16 + 7), 20'h0, 1'b0);
      end
      queue_request(KIND_LOAD, 20'd1, 20'd2, 20'h0, 1'b0);
      queue_request(KIND_QUERY, 20'h0, 20'h0, 20'((TABLE_ENTRIES_DEF - 1) * 16 + 7), 1'b0);
      queue_request(KIND_QUERY, 20'h0, 20'h0, 20'(512 * 16), 1'b0);
      queue_request(KIND_QUERY, 20'h0, 20'h0, 20'd8, 1'b0);
      queue_request(KIND_LOAD, 20'hFFFFF, 20'hFFFFF, 20'h0, 1'b0);
      queue_request(KIND_CLEAR, 20'h0, 20'h0, 20'h0, 1'b0);

      // Random episodes: a burst of clustered ranges followed by lookups around them.
      made = 0;
      table_size = 0;
      while (made < 580) begin
         if ($urandom_range(0, 99) < 4) begin
            queue_request(KIND_UNUSED, 20'($urandom), 20'($urandom), 20'($urandom), 1'b0);
         end
         if (table_size > 100 || $urandom_range(0, 3) == 0) begin
            queue_request(KIND_CLEAR, 20'($urandom), 20'($urandom), 20'($urandom),
                          $urandom_range(0, 99) == 0);
            table_size = 0;
            made++;
         end
         base = $urandom_range(0, 20'hFFFFF - 600);
         nload = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
         for (j = 0; j < nload; j++) begin
            lo = 20'(base + $urandom_range(0, 300));
            hi = 20'(lo + $urandom_range(0, 200));
            if ($urandom_range(0, 9) == 0) begin
               swap = lo;
               lo = hi;
               hi = swap;
            end
            if ($urandom_range(0, 19) == 0) begin
               lo = 20'($urandom);
               hi = 20'($urandom);
            end
            queue_request(KIND_LOAD, lo, hi, 20'($urandom), $urandom_range(0, 99) == 0);
            table_size++;
            made++;
         end
         nquery = $urandom_range(1, 10);
         for (j = 0; j < nquery; j++) begin
            pr = ($urandom_range(0, 7) == 0) ? 20'($urandom) : 20'(base + $urandom_range(0, 600));
            queue_request(KIND_QUERY, 20'($urandom), 20'($urandom), pr,
                          $urandom_range(0, 99) == 0);
            made++;
         end
      end
      total_planned = pending.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      while (pending.size() != 0 || req_valid || due_answers.size() != 0) begin
         @(posedge clock);
      end
      // A late or spurious result could still follow the longest scan.
      repeat (SCAN_SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d accepted requests, including a full table and its overflow.",
               accepted);
      $display("Results: %0d unique, %0d no match, %0d ambiguous, %0d loaded, %0d dropped, %0d cleared.",
               status_seen[ST_UNIQUE], status_seen[ST_NONE], status_seen[ST_AMBIG],
               status_seen[ST_LOADED], status_seen[ST_FULL], status_seen[ST_CLEARED]);
      if (errors == 0) begin
         $display("unique_range_match_table_top_tb: done, clean");
      end else begin
         $display("unique_range_match_table_top_tb: done, errors");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+rtl
rtl/urmt_pkg.sv
rtl/urmt_store.sv
rtl/unique_range_match_table_top.sv
rtl/urmt_check.sv
sim/unique_range_match_table_top_tb.sv
